// ===== design/ngis_pkg.sv =====
// ----------------------------------------------------------------------------
// ngis_pkg: shared types and constants of the next greater index stack
// Sizes of the stack and the position counter, and the records that travel
// between the front end, the queue and the back end.
// ----------------------------------------------------------------------------
package ngis_pkg;

  localparam int StackDepth = 32;
  localparam int IndexW     = 16;
  localparam int ValueW     = 32;
  localparam int CntW       = $clog2(StackDepth + 1);
  localparam int AddrW      = $clog2(StackDepth);
  localparam int NextW      = IndexW + 1;
  localparam int OutDataW   = ((IndexW + NextW + 7) / 8) * 8;
  localparam int InDataW    = ((ValueW + 7) / 8) * 8;

  localparam logic [IndexW-1:0] IndexMax = '1;
  localparam logic [NextW-1:0]  NextNone = '1;
  localparam logic [ValueW-1:0] SignFlip = {1'b1, {(ValueW-1){1'b0}}};

  // One classified element as handed from the front end to the back end.
  typedef struct packed {
    logic [ValueW-1:0] key;      // value with the sign bit flipped
    logic [IndexW-1:0] pos;
    logic              final_q;  // last element of the sequence
    logic              sat;      // position counter was saturated
  } item_t;

  // One stack entry.
  typedef struct packed {
    logic [IndexW-1:0] pos;
    logic [ValueW-1:0] key;
  } entry_t;

  // One result without its run_end flag.
  typedef struct packed {
    logic              overflow;
    logic [NextW-1:0]  next_pos;
    logic [IndexW-1:0] pos;
  } result_t;

endpackage

// ===== design/ngis_front.sv =====
// ----------------------------------------------------------------------------
// ngis_front: element numbering and classification
// Numbers incoming elements, saturates the counter at its top code and turns
// the signed value into an unsigned compare key.
// ----------------------------------------------------------------------------
module ngis_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic [ngis_pkg::ValueW-1:0] in_value_i,
  input  logic                        in_final_i,
  input  logic                        queue_full_i,
  output logic                        in_ready_o,
  output logic                        push_o,
  output ngis_pkg::item_t             item_o
);

  logic [ngis_pkg::IndexW-1:0] index_q, index_d;
  logic                        sat;

  assign in_ready_o = !queue_full_i;
  assign push_o     = in_valid_i && !queue_full_i;
  assign sat        = (index_q == ngis_pkg::IndexMax);

  assign item_o.key     = in_value_i ^ ngis_pkg::SignFlip;
  assign item_o.pos     = index_q;
  assign item_o.final_q = in_final_i;
  assign item_o.sat     = sat;

  always_comb begin
    index_d = index_q;
    if (push_o) begin
      if (in_final_i) begin
        index_d = '0;
      end else if (!sat) begin
        index_d = index_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      index_q <= '0;
    end else begin
      index_q <= index_d;
    end
  end

endmodule

// ===== design/ngis_fifo.sv =====
// ----------------------------------------------------------------------------
// ngis_fifo: two-entry queue between front end and back end
// Lets the front end take a new element while the back end is still busy.
// ----------------------------------------------------------------------------
module ngis_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  ngis_pkg::item_t push_data_i,
  input  logic            pop_i,
  output logic            full_o,
  output logic            valid_o,
  output ngis_pkg::item_t pop_data_o
);

  ngis_pkg::item_t mem_q [2];
  logic            wr_ptr_q, rd_ptr_q;
  logic [1:0]      count_q;

  assign full_o     = (count_q == 2'd2);
  assign valid_o    = (count_q != 2'd0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      count_q <= count_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

endmodule

// ===== design/ngis_back.sv =====
// ----------------------------------------------------------------------------
// ngis_back: monotonic stack engine
// Pops smaller entries one per cycle unless stalled, pushes the new element,
// flushes the stack on the last element, drives the registered result stage.
// ----------------------------------------------------------------------------
module ngis_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              item_valid_i,
  input  ngis_pkg::item_t   item_i,
  output logic              item_pop_o,
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output ngis_pkg::result_t res_o,
  output logic              res_last_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_FLUSH
  } state_e;

  state_e                    state_q, state_d;
  logic [ngis_pkg::CntW-1:0] cnt_q, cnt_d;
  logic                      ovf_q, ovf_d;
  ngis_pkg::item_t           cur_q, cur_d;
  ngis_pkg::result_t         pend_q, pend_d;
  logic                      pend_v_q, pend_v_d;
  ngis_pkg::result_t         res_q, res_d;
  logic                      res_v_q, res_v_d;
  logic                      res_last_q, res_last_d;

  ngis_pkg::entry_t           mem [ngis_pkg::StackDepth];
  ngis_pkg::entry_t           rd_q;
  logic [ngis_pkg::AddrW-1:0] rd_addr;
  logic                       we;
  ngis_pkg::entry_t           wdata;
  logic                       out_free;
  logic                       pop_c;

  assign out_free = !res_v_q || res_ready_i;
  assign pop_c    = (cnt_q != '0) && (cur_q.key > rd_q.key);
  assign wdata    = '{pos: cur_q.pos, key: cur_q.key};
  // The entry read for the next cycle is the top of the stack after this one.
  assign rd_addr  = ngis_pkg::AddrW'(cnt_d - 1'b1);

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    ovf_d      = ovf_q;
    cur_d      = cur_q;
    pend_d     = pend_q;
    pend_v_d   = pend_v_q;
    res_d      = res_q;
    res_v_d    = res_v_q;
    res_last_d = res_last_q;
    we         = 1'b0;
    item_pop_o = 1'b0;
    if (res_v_q && res_ready_i) begin
      res_v_d = 1'b0;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (item_valid_i) begin
          item_pop_o = 1'b1;
          cur_d      = item_i;
          ovf_d      = ovf_q | item_i.sat;
          state_d    = ST_CMP;
        end
      end
      ST_CMP: begin
        if (!pend_v_q || out_free) begin
          // The held result is released once it is known whether more follow.
          if (pend_v_q) begin
            res_v_d    = 1'b1;
            res_d      = pend_q;
            res_last_d = !pop_c && !cur_q.final_q;
          end
          if (pop_c) begin
            pend_d   = '{overflow: ovf_q, next_pos: {1'b0, cur_q.pos}, pos: rd_q.pos};
            pend_v_d = 1'b1;
            cnt_d    = cnt_q - 1'b1;
          end else if (cur_q.final_q) begin
            pend_d   = '{overflow: ovf_q, next_pos: ngis_pkg::NextNone, pos: cur_q.pos};
            pend_v_d = 1'b1;
            state_d  = ST_FLUSH;
          end else begin
            pend_v_d = 1'b0;
            if (cnt_q < ngis_pkg::CntW'(ngis_pkg::StackDepth)) begin
              we    = 1'b1;
              cnt_d = cnt_q + 1'b1;
            end else begin
              ovf_d = 1'b1;
            end
            state_d = ST_IDLE;
          end
        end
      end
      ST_FLUSH: begin
        if (out_free) begin
          res_v_d    = 1'b1;
          res_d      = pend_q;
          res_last_d = (cnt_q == '0);
          if (cnt_q != '0) begin
            pend_d = '{overflow: ovf_q, next_pos: ngis_pkg::NextNone, pos: rd_q.pos};
            cnt_d  = cnt_q - 1'b1;
          end else begin
            pend_v_d = 1'b0;
            ovf_d    = 1'b0;
            state_d  = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[cnt_q[ngis_pkg::AddrW-1:0]] <= wdata;
    end
    rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      cnt_q      <= '0;
      ovf_q      <= 1'b0;
      pend_v_q   <= 1'b0;
      res_v_q    <= 1'b0;
      res_last_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      ovf_q      <= ovf_d;
      pend_v_q   <= pend_v_d;
      res_v_q    <= res_v_d;
      res_last_q <= res_last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q  <= cur_d;
    pend_q <= pend_d;
    res_q  <= res_d;
  end

  assign res_valid_o = res_v_q;
  assign res_o       = res_q;
  assign res_last_o  = res_last_q;

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= ngis_pkg::CntW'(ngis_pkg::StackDepth))
    else $error("stack count beyond depth");

  a_flush_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_FLUSH |-> pend_v_q)
    else $error("flush without a held result");

  a_idle_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE |-> !pend_v_q)
    else $error("held result left behind at item boundary");

  a_flush_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FLUSH && state_d == ST_IDLE) |=> (cnt_q == '0 && !ovf_q))
    else $error("sequence state not cleared after flush");

endmodule

// ===== design/next_greater_index_stack.sv =====
// ----------------------------------------------------------------------------
// next_greater_index_stack: next greater element by a monotonic stack
// Numbers a stream of signed values and reports for each one the position of
// the first later, strictly greater value, using a stack of open elements.
// ----------------------------------------------------------------------------
//
//   Channel   Dir  tdata (low bit up)                   tlast     tuser
//   s_axis    in   value[31:0]                          is_final  -
//   m_axis    out  position[15:0], next_position[32:16] run_end   overflow
//
// The front end numbers each element and writes it to a two-entry queue in
// the cycle it is accepted, so input requests are taken while the back end
// is still working. The back end pops each smaller entry in turn and then
// pushes the element; the last element of a sequence instead emits its own
// result and one for each entry left on the stack. Each cycle the stack
// memory is read once, at the current top, with a registered read port. A
// pop result is held in a pending register so that its run_end flag is known
// before it reaches the output register. Reset clears the stack count, the
// position counter and the overflow flag; no clearing pass is needed. Output
// stalls back up into the stack engine, then the queue, then the input.
//
module next_greater_index_stack (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [ngis_pkg::InDataW-1:0]  s_axis_tdata_i,   // value
  input  logic                          s_axis_tlast_i,   // is_final
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  output logic [ngis_pkg::OutDataW-1:0] m_axis_tdata_o,   // position, next_position, zeros
  output logic                          m_axis_tlast_o,   // run_end
  output logic                          m_axis_tuser_o    // overflow
);

  logic              push;
  logic              queue_full;
  logic              queue_valid;
  logic              queue_pop;
  ngis_pkg::item_t   front_item;
  ngis_pkg::item_t   queue_item;
  ngis_pkg::result_t res;

  // Front end: numbering, counter saturation and compare key.
  ngis_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid_i),
    .in_value_i   (s_axis_tdata_i[ngis_pkg::ValueW-1:0]),
    .in_final_i   (s_axis_tlast_i),
    .queue_full_i (queue_full),
    .in_ready_o   (s_axis_tready_o),
    .push_o       (push),
    .item_o       (front_item)
  );

  // Decoupling queue.
  ngis_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (front_item),
    .pop_i       (queue_pop),
    .full_o      (queue_full),
    .valid_o     (queue_valid),
    .pop_data_o  (queue_item)
  );

  // Back end: stack pops, pushes, final flush and the result register.
  ngis_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (queue_valid),
    .item_i       (queue_item),
    .item_pop_o   (queue_pop),
    .res_valid_o  (m_axis_tvalid_o),
    .res_ready_i  (m_axis_tready_i),
    .res_o        (res),
    .res_last_o   (m_axis_tlast_o)
  );

  // Results are packed position first, padded with zeros to whole bytes.
  assign m_axis_tdata_o = {{(ngis_pkg::OutDataW - ngis_pkg::IndexW - ngis_pkg::NextW){1'b0}},
                           res.next_pos, res.pos};
  assign m_axis_tuser_o = res.overflow;

endmodule
